### hw/rtl/sc1dec_pkg.sv
`default_nettype none

package sc1dec_pkg;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_EXT  = 4'd1,
    PH_PS1  = 4'd2,
    PH_PS2  = 4'd3,
    PH_BR1  = 4'd4,
    PH_BR2  = 4'd5,
    PH_P1   = 4'd6,
    PH_P2   = 4'd7,
    PH_P3   = 4'd8,
    PH_P4   = 4'd9,
    PH_P5   = 4'd10
  } phase_t;

  localparam logic [2:0] KIND_PLAIN  = 3'd0;
  localparam logic [2:0] KIND_EXT    = 3'd1;
  localparam logic [2:0] KIND_PRTSCR = 3'd2;
  localparam logic [2:0] KIND_BREAK  = 3'd3;
  localparam logic [2:0] KIND_PAUSE  = 3'd4;

  localparam logic [7:0] BYTE_ACK    = 8'hfa;
  localparam logic [7:0] BYTE_RESEND = 8'hfe;
  localparam logic [7:0] BYTE_E0     = 8'he0;
  localparam logic [7:0] BYTE_E1     = 8'he1;
  localparam logic [7:0] BYTE_PS_A   = 8'h2a;
  localparam logic [7:0] BYTE_PS_B   = 8'h37;
  localparam logic [7:0] BYTE_BR_A   = 8'h46;
  localparam logic [7:0] BYTE_BR_B   = 8'hc6;
  localparam logic [7:0] BYTE_PA_A   = 8'h1d;
  localparam logic [7:0] BYTE_PA_B   = 8'h45;
  localparam logic [7:0] BYTE_PA_C   = 8'h9d;
  localparam logic [7:0] BYTE_PA_D   = 8'hc5;

  typedef struct packed {
    logic       emit;
    logic [2:0] kind;
    logic [6:0] code;
    logic       released;
    logic       known;
  } key_result_t;

  function automatic logic plain_known(input logic [6:0] c);
    plain_known = ((c >= 7'h01) && (c <= 7'h53)) || (c == 7'h57) || (c == 7'h58);
  endfunction

  function automatic logic ext_known(input logic [6:0] c);
    case (c)
      7'h1c, 7'h1d, 7'h35, 7'h37, 7'h38,
      7'h47, 7'h48, 7'h49, 7'h4b, 7'h4d,
      7'h4f, 7'h50, 7'h51, 7'h52, 7'h53: ext_known = 1'b1;
      default:                           ext_known = 1'b0;
    endcase
  endfunction

endpackage

`default_nettype wire

### hw/rtl/scancode_set1_decoder.sv
// an accepted scan byte goes to the input register, then its key event to the result
// register; one scan byte per cycle unless key_stall holds a pending key event; the
// phase and result registers both update as the byte leaves the input register
// reset: rst (synchronous) returns the phase to idle and empties both registers
`default_nettype none

module scancode_set1_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       scan_valid,
  output logic            scan_stall,
  input  wire logic [7:0] scan_byte,
  output logic            key_valid,
  input  wire logic       key_stall,
  output logic [2:0]      key_kind,
  output logic [6:0]      key_code,
  output logic            released,
  output logic            known
);

  logic                    byte_valid;
  logic [7:0]              byte_q;
  logic                    advance;
  sc1dec_pkg::phase_t      phase;
  sc1dec_pkg::phase_t      phase_next;
  sc1dec_pkg::key_result_t result;

  assign advance    = byte_valid && (!key_valid || !key_stall);
  assign scan_stall = byte_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!scan_stall) begin
      byte_valid <= scan_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_valid && !scan_stall) begin
      byte_q <= scan_byte;
    end
  end

  sc1dec_step u_step (
    .scan_byte  (byte_q),
    .phase      (phase),
    .phase_next (phase_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sc1dec_pkg::PH_IDLE;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (advance) begin
      key_valid <= result.emit;
    end else if (!key_stall) begin
      key_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      key_kind <= result.kind;
      key_code <= result.code;
      released <= result.released;
      known    <= result.known;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sc1dec_step.sv
`default_nettype none

module sc1dec_step (
  input  wire logic [7:0]              scan_byte,
  input  wire sc1dec_pkg::phase_t      phase,
  output sc1dec_pkg::phase_t           phase_next,
  output sc1dec_pkg::key_result_t      result
);

  sc1dec_pkg::key_result_t key_res;
  sc1dec_pkg::key_result_t special_res;

  always_comb begin
    key_res.emit     = 1'b1;
    key_res.code     = scan_byte[6:0];
    key_res.released = scan_byte[7];
    if (phase == sc1dec_pkg::PH_EXT) begin
      key_res.kind  = sc1dec_pkg::KIND_EXT;
      key_res.known = sc1dec_pkg::ext_known(scan_byte[6:0]);
    end else begin
      key_res.kind  = sc1dec_pkg::KIND_PLAIN;
      key_res.known = sc1dec_pkg::plain_known(scan_byte[6:0]);
    end
  end

  always_comb begin
    special_res.emit     = 1'b1;
    special_res.code     = 7'd0;
    special_res.released = 1'b0;
    special_res.known    = 1'b1;
    unique case (phase)
      sc1dec_pkg::PH_PS2: special_res.kind = sc1dec_pkg::KIND_PRTSCR;
      sc1dec_pkg::PH_BR2: special_res.kind = sc1dec_pkg::KIND_BREAK;
      default:            special_res.kind = sc1dec_pkg::KIND_PAUSE;
    endcase
  end

  // next phase
  always_comb begin
    phase_next = sc1dec_pkg::PH_IDLE;
    unique case (phase)
      sc1dec_pkg::PH_EXT: begin
        if (scan_byte == sc1dec_pkg::BYTE_PS_A) phase_next = sc1dec_pkg::PH_PS1;
        else if (scan_byte == sc1dec_pkg::BYTE_BR_A) phase_next = sc1dec_pkg::PH_BR1;
        else if (scan_byte == sc1dec_pkg::BYTE_E1) phase_next = sc1dec_pkg::PH_P1;
      end
      sc1dec_pkg::PH_PS1: begin
        if (scan_byte == sc1dec_pkg::BYTE_E0) phase_next = sc1dec_pkg::PH_PS2;
      end
      sc1dec_pkg::PH_BR1: begin
        if (scan_byte == sc1dec_pkg::BYTE_E0) phase_next = sc1dec_pkg::PH_BR2;
      end
      sc1dec_pkg::PH_P1: begin
        if (scan_byte == sc1dec_pkg::BYTE_PA_A) phase_next = sc1dec_pkg::PH_P2;
      end
      sc1dec_pkg::PH_P2: begin
        if (scan_byte == sc1dec_pkg::BYTE_PA_B) phase_next = sc1dec_pkg::PH_P3;
      end
      sc1dec_pkg::PH_P3: begin
        if (scan_byte == sc1dec_pkg::BYTE_E1) phase_next = sc1dec_pkg::PH_P4;
      end
      sc1dec_pkg::PH_P4: begin
        if (scan_byte == sc1dec_pkg::BYTE_PA_C) phase_next = sc1dec_pkg::PH_P5;
      end
      sc1dec_pkg::PH_PS2, sc1dec_pkg::PH_BR2, sc1dec_pkg::PH_P5: begin
        phase_next = sc1dec_pkg::PH_IDLE;
      end
      default: begin
        if (scan_byte == sc1dec_pkg::BYTE_E0) phase_next = sc1dec_pkg::PH_EXT;
        else if (scan_byte == sc1dec_pkg::BYTE_E1) phase_next = sc1dec_pkg::PH_P1;
      end
    endcase
  end

  // result
  always_comb begin
    result      = key_res;
    result.emit = 1'b0;
    unique case (phase)
      sc1dec_pkg::PH_EXT: begin
        result.emit = (scan_byte != sc1dec_pkg::BYTE_PS_A) &&
                      (scan_byte != sc1dec_pkg::BYTE_BR_A) &&
                      (scan_byte != sc1dec_pkg::BYTE_E1);
      end
      sc1dec_pkg::PH_PS2: begin
        result      = special_res;
        result.emit = (scan_byte == sc1dec_pkg::BYTE_PS_B);
      end
      sc1dec_pkg::PH_BR2: begin
        result      = special_res;
        result.emit = (scan_byte == sc1dec_pkg::BYTE_BR_B);
      end
      sc1dec_pkg::PH_P5: begin
        result      = special_res;
        result.emit = (scan_byte == sc1dec_pkg::BYTE_PA_D);
      end
      sc1dec_pkg::PH_PS1, sc1dec_pkg::PH_BR1, sc1dec_pkg::PH_P1,
      sc1dec_pkg::PH_P2, sc1dec_pkg::PH_P3, sc1dec_pkg::PH_P4: begin
        result.emit = 1'b0;
      end
      default: begin
        result.emit = (scan_byte != sc1dec_pkg::BYTE_ACK) &&
                      (scan_byte != sc1dec_pkg::BYTE_RESEND) &&
                      (scan_byte != sc1dec_pkg::BYTE_E0) &&
                      (scan_byte != sc1dec_pkg::BYTE_E1);
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/sc1dec_check.sv
`default_nettype none

module sc1dec_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       key_valid,
  input wire logic       key_stall,
  input wire logic [2:0] key_kind,
  input wire logic [6:0] key_code,
  input wire logic       released,
  input wire logic       known
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !key_valid)
    else $error("key transaction pending after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_stall |=> key_valid && $stable(key_kind) && $stable(key_code) &&
      $stable(released) && $stable(known))
    else $error("stalled key transaction changed");

  a_special: assert property (@(posedge clk) disable iff (rst)
    key_valid && (key_kind == sc1dec_pkg::KIND_PRTSCR ||
      key_kind == sc1dec_pkg::KIND_BREAK || key_kind == sc1dec_pkg::KIND_PAUSE)
      |-> key_code == 7'd0 && !released && known)
    else $error("special key carries a code");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> key_kind <= sc1dec_pkg::KIND_PAUSE)
    else $error("key kind out of range");

  a_plain_known: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_kind == sc1dec_pkg::KIND_PLAIN && known |-> key_code != 7'd0)
    else $error("code zero marked known");

endmodule

bind scancode_set1_decoder sc1dec_check u_sc1dec_check (
  .clk        (clk),
  .rst        (rst),
  .key_valid  (key_valid),
  .key_stall  (key_stall),
  .key_kind   (key_kind),
  .key_code   (key_code),
  .released   (released),
  .known      (known)
);

`default_nettype wire
